[design/mscf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mscf_pkg
// Shared types and constants for the motor command RTU framer.
// ----------------------------------------------------------------------------
package mscf_pkg;

   // command opcodes
   localparam logic [1:0] OP_ESTOP    = 2'd0;
   localparam logic [1:0] OP_VELOCITY = 2'd1;
   localparam logic [1:0] OP_ABSOLUTE = 2'd2;
   localparam logic [1:0] OP_RELATIVE = 2'd3;

   // control register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTOR_ID       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FUNCTION_CODE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_MARKER = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_SPEED  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_ACCEL  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_DECEL  = 3'd5;

   // control register reset values
   localparam logic [7:0]  RST_MOTOR_ID       = 8'd1;
   localparam logic [7:0]  RST_FUNCTION_CODE  = 8'd6;
   localparam logic [15:0] RST_DEFAULT_MARKER = 16'hFFFF;
   localparam logic [15:0] RST_DEFAULT_SPEED  = 16'h0000;
   localparam logic [15:0] RST_DEFAULT_ACCEL  = 16'h0000;
   localparam logic [15:0] RST_DEFAULT_DECEL  = 16'h0000;

   // command queue depth between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic [7:0]  motor_id;
      logic [7:0]  function_code;
      logic [15:0] default_marker;
      logic [15:0] default_speed;
      logic [15:0] default_accel;
      logic [15:0] default_decel;
   } cfg_type;

   // classified command, defaults already applied
   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] position;
      logic [15:0] speed;
      logic [15:0] accel;
      logic [15:0] decel;
   } cmd_type;

endpackage
`default_nettype wire

[design/mscf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mscf_front
// Accepts motor commands, substitutes configured defaults for marker values
// and pushes the result into the command queue.
// ----------------------------------------------------------------------------
module mscf_front (
   input  mscf_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [31:0]       req_target_position,
   input  logic [15:0]       req_move_speed,
   input  logic [15:0]       req_move_accel,
   input  logic [15:0]       req_move_decel,
   input  logic              q_full,
   output logic              q_push,
   output mscf_pkg::cmd_type q_data
);
   import mscf_pkg::*;

   logic pos_mode;

   // back pressure straight from queue occupancy
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // speed default only applies to position moves
   assign pos_mode = (req_opcode == OP_ABSOLUTE) || (req_opcode == OP_RELATIVE);

   // default substitution
   always_comb begin
      q_data.opcode   = req_opcode;
      q_data.position = req_target_position;
      q_data.speed    = (pos_mode && (req_move_speed == cfg.default_marker)) ?
                        cfg.default_speed : req_move_speed;
      q_data.accel    = (req_move_accel == cfg.default_marker) ?
                        cfg.default_accel : req_move_accel;
      q_data.decel    = (req_move_decel == cfg.default_marker) ?
                        cfg.default_decel : req_move_decel;
   end

endmodule
`default_nettype wire

[design/mscf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mscf_queue
// Small register FIFO holding classified commands between front and back.
// ----------------------------------------------------------------------------
module mscf_queue #(
   parameter int DEPTH = mscf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mscf_pkg::cmd_type push_data,
   input  logic              pop,
   output mscf_pkg::cmd_type pop_data,
   output logic              full,
   output logic              empty
);
   import mscf_pkg::*;

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == COUNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[design/mscf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mscf_back
// Walks the frame series of one command, one byte per cycle unless rsp_stall holds it,
// accumulating the CRC-16 over the first six bytes of each frame.
// ----------------------------------------------------------------------------
module mscf_back (
   input  logic              clock,
   input  logic              reset,
   input  mscf_pkg::cfg_type cfg,
   input  logic              q_empty,
   input  mscf_pkg::cmd_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_frame_byte,
   output logic              rsp_end_of_frame,
   output logic              rsp_last
);
   import mscf_pkg::*;

   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] ADDR_CONTROL  = 16'h6002;
   localparam logic [15:0] ADDR_PATH     = 16'h6200;
   localparam logic [15:0] ADDR_POS_HI   = 16'h6201;
   localparam logic [15:0] ADDR_POS_LO   = 16'h6202;
   localparam logic [15:0] ADDR_SPEED    = 16'h6203;
   localparam logic [15:0] ADDR_ACCEL    = 16'h6204;
   localparam logic [15:0] ADDR_DECEL    = 16'h6205;
   localparam logic [15:0] CTRL_TRIGGER  = 16'h0010;
   localparam logic [15:0] CTRL_ESTOP    = 16'h0040;
   localparam logic [15:0] MODE_ABSOLUTE = 16'h0001;
   localparam logic [15:0] MODE_RELATIVE = 16'h0041;
   localparam logic [15:0] MODE_VELOCITY = 16'h0002;

   localparam logic [2:0] BYTE_ID     = 3'd0;
   localparam logic [2:0] BYTE_FUNC   = 3'd1;
   localparam logic [2:0] BYTE_ADR_HI = 3'd2;
   localparam logic [2:0] BYTE_ADR_LO = 3'd3;
   localparam logic [2:0] BYTE_DAT_HI = 3'd4;
   localparam logic [2:0] BYTE_DAT_LO = 3'd5;
   localparam logic [2:0] BYTE_CRC_LO = 3'd6;
   localparam logic [2:0] BYTE_CRC_HI = 3'd7;

   // one frame per step; velocity skips the position steps, estop only trigger
   typedef enum logic [2:0] {
      STEP_PATH,
      STEP_POS_HI,
      STEP_POS_LO,
      STEP_SPEED,
      STEP_ACCEL,
      STEP_DECEL,
      STEP_TRIGGER
   } step_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc_val,
                                              input logic [7:0]  data_byte);
      logic [15:0] c;
      c = crc_val ^ {8'h00, data_byte};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   logic        active_ff;
   cmd_type     cmd_ff;
   step_type    step_ff;
   step_type    step_in;
   logic [2:0]  byte_ff;
   logic [15:0] crc_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_eof_ff;
   logic        rsp_last_ff;

   logic        emit_ok, fire, cmd_done, load;
   logic [15:0] reg_addr, reg_data, mode_data, crc_base;
   logic [7:0]  cur_byte;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_byte   = rsp_byte_ff;
   assign rsp_end_of_frame = rsp_eof_ff;
   assign rsp_last         = rsp_last_ff;

   // output slot free or being drained this cycle
   assign emit_ok  = !rsp_valid_ff || !rsp_stall;
   assign fire     = active_ff && emit_ok;
   assign cmd_done = fire && (byte_ff == BYTE_CRC_HI) && (step_ff == STEP_TRIGGER);
   assign load     = !active_ff || cmd_done;
   assign q_pop    = load && !q_empty;

   // path mode word by opcode
   always_comb begin
      unique case (cmd_ff.opcode)
         OP_VELOCITY: mode_data = MODE_VELOCITY;
         OP_ABSOLUTE: mode_data = MODE_ABSOLUTE;
         default:     mode_data = MODE_RELATIVE;
      endcase
   end

   // register address and data of the current frame
   always_comb begin
      unique case (step_ff)
         STEP_PATH:   begin reg_addr = ADDR_PATH;   reg_data = mode_data;             end
         STEP_POS_HI: begin reg_addr = ADDR_POS_HI; reg_data = cmd_ff.position[31:16]; end
         STEP_POS_LO: begin reg_addr = ADDR_POS_LO; reg_data = cmd_ff.position[15:0];  end
         STEP_SPEED:  begin reg_addr = ADDR_SPEED;  reg_data = cmd_ff.speed;           end
         STEP_ACCEL:  begin reg_addr = ADDR_ACCEL;  reg_data = cmd_ff.accel;           end
         STEP_DECEL:  begin reg_addr = ADDR_DECEL;  reg_data = cmd_ff.decel;           end
         default: begin
            reg_addr = ADDR_CONTROL;
            reg_data = (cmd_ff.opcode == OP_ESTOP) ? CTRL_ESTOP : CTRL_TRIGGER;
         end
      endcase
   end

   // byte select within the frame
   always_comb begin
      unique case (byte_ff)
         BYTE_ID:     cur_byte = cfg.motor_id;
         BYTE_FUNC:   cur_byte = cfg.function_code;
         BYTE_ADR_HI: cur_byte = reg_addr[15:8];
         BYTE_ADR_LO: cur_byte = reg_addr[7:0];
         BYTE_DAT_HI: cur_byte = reg_data[15:8];
         BYTE_DAT_LO: cur_byte = reg_data[7:0];
         BYTE_CRC_LO: cur_byte = crc_ff[7:0];
         default:     cur_byte = crc_ff[15:8];
      endcase
   end

   assign crc_base = (byte_ff == BYTE_ID) ? CRC_INIT : crc_ff;

   // next frame of the series
   always_comb begin
      if ((cmd_ff.opcode == OP_VELOCITY) && (step_ff == STEP_PATH)) begin
         step_in = STEP_SPEED;
      end else if (step_ff == STEP_TRIGGER) begin
         step_in = STEP_TRIGGER;
      end else begin
         step_in = step_type'(step_ff + 3'd1);
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= STEP_PATH;
         byte_ff      <= BYTE_ID;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            active_ff <= 1'b1;
            cmd_ff    <= q_data;
            step_ff   <= (q_data.opcode == OP_ESTOP) ? STEP_TRIGGER : STEP_PATH;
            byte_ff   <= BYTE_ID;
         end else if (cmd_done) begin
            active_ff <= 1'b0;
         end else if (fire) begin
            byte_ff <= byte_ff + 3'd1;
            if (byte_ff == BYTE_CRC_HI) begin
               step_ff <= step_in;
            end
         end
         // crc runs over the six header and data bytes
         if (fire && (byte_ff < BYTE_CRC_LO)) begin
            crc_ff <= crc_update(crc_base, cur_byte);
         end
         if (emit_ok) begin
            rsp_valid_ff <= fire;
            rsp_byte_ff  <= cur_byte;
            rsp_eof_ff   <= (byte_ff == BYTE_CRC_HI);
            rsp_last_ff  <= (byte_ff == BYTE_CRC_HI) && (step_ff == STEP_TRIGGER);
         end
      end
   end

endmodule
`default_nettype wire

[design/modbus_stepper_command_framer.sv]
`timescale 1ns / 1ps
`default_nettype none
// A command passes the queue, the framer command register and the output byte register.
// Throughput: one frame byte per cycle from the single output byte register unless
// rsp_stall is high; an estop is one frame, a velocity move five, an absolute or
// relative move seven. Commands queue in front of the framer and follow each other with no gap.
// Reset: control registers return to their defaults, queue and framer empty.
// ----------------------------------------------------------------------------
// modbus_stepper_command_framer
// Turns motor commands into Modbus RTU write-single-register frame bytes.
// ----------------------------------------------------------------------------
module modbus_stepper_command_framer #(
   parameter int QUEUE_DEPTH = mscf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // control register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mscf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mscf_pkg::CSR_DATA_W-1:0]   csr_data,
   // command input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_opcode,
   input  logic [31:0]                       req_target_position,
   input  logic [15:0]                       req_move_speed,
   input  logic [15:0]                       req_move_accel,
   input  logic [15:0]                       req_move_decel,
   // frame byte output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_frame_byte,
   output logic                              rsp_end_of_frame,
   output logic                              rsp_last
);
   import mscf_pkg::*;

   cfg_type cfg_ff;
   cmd_type push_data, pop_data;
   logic    q_push, q_pop, q_full, q_empty;

   // control registers, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motor_id       <= RST_MOTOR_ID;
         cfg_ff.function_code  <= RST_FUNCTION_CODE;
         cfg_ff.default_marker <= RST_DEFAULT_MARKER;
         cfg_ff.default_speed  <= RST_DEFAULT_SPEED;
         cfg_ff.default_accel  <= RST_DEFAULT_ACCEL;
         cfg_ff.default_decel  <= RST_DEFAULT_DECEL;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MOTOR_ID:       cfg_ff.motor_id       <= csr_data[7:0];
            CSR_FUNCTION_CODE:  cfg_ff.function_code  <= csr_data[7:0];
            CSR_DEFAULT_MARKER: cfg_ff.default_marker <= csr_data;
            CSR_DEFAULT_SPEED:  cfg_ff.default_speed  <= csr_data;
            CSR_DEFAULT_ACCEL:  cfg_ff.default_accel  <= csr_data;
            CSR_DEFAULT_DECEL:  cfg_ff.default_decel  <= csr_data;
            default: ;
         endcase
      end
   end

   // command classification
   mscf_front u_front (
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_target_position (req_target_position),
      .req_move_speed      (req_move_speed),
      .req_move_accel      (req_move_accel),
      .req_move_decel      (req_move_decel),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_data              (push_data)
   );

   // decoupling queue
   mscf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // frame sequencer
   mscf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_data           (pop_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_last         (rsp_last)
   );

   // the last byte of a command always closes a frame
   a_last_is_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_end_of_frame)
      else $error("last byte without end of frame");

   // a transferred command is held in the queue on the next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !q_empty)
      else $error("accepted command missing from queue");

   // a transferred frame end is never directly followed by another frame end
   a_no_double_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_end_of_frame |=> !(rsp_valid && rsp_end_of_frame))
      else $error("end of frame on consecutive bytes");

endmodule
`default_nettype wire
